/* hdl/fwh_pkg.sv */
`timescale 1ns / 1ps

package fwh_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned VAL_W       = 7;
  localparam int unsigned BINS_W      = 7;
  localparam int unsigned IDX_OUT_W   = 6;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned APB_AW      = 2;
  localparam int unsigned APB_DW      = 32;

  localparam int unsigned VALUE_SPAN      = 100;
  localparam int unsigned RESET_BIN_COUNT = 10;

  // index = (value * recip) >> RECIP_SHIFT, exact while value * width < 2**RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 14;
  localparam int unsigned DIV_W       = RECIP_SHIFT + 1;
  localparam int unsigned STEP_W      = $clog2(DIV_W + 1);
  localparam int unsigned PROD_W      = VAL_W + DIV_W;

  localparam logic [APB_AW-1:0] ADDR_BIN_COUNT = APB_AW'(0);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_DUMP  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_DUMP,
    ST_DIV_WIDTH,
    ST_DIV_RECIP
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [BINS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* hdl/fwh_if.sv */
`timescale 1ns / 1ps

interface fwh_smp_if;
  logic                       valid;
  logic                       ready;
  logic [fwh_pkg::MODE_W-1:0] mode;
  logic [fwh_pkg::VAL_W-1:0]  sample_value;

  modport source (output valid, mode, sample_value, input ready);
  modport sink (input valid, mode, sample_value, output ready);
endinterface

interface fwh_res_if;
  logic                          valid;
  logic                          ready;
  logic [fwh_pkg::IDX_OUT_W-1:0] bin_index;
  logic [fwh_pkg::TOTAL_W-1:0]   bin_total;
  logic                          last_bin;

  modport source (output valid, bin_index, bin_total, last_bin, input ready);
  modport sink (input valid, bin_index, bin_total, last_bin, output ready);
endinterface

/* hdl/fixed_width_histogram.sv */
`timescale 1ns / 1ps

// Fixed-width histogram. Add and clear requests are taken one per cycle and run through a
// read-modify-write pipeline on a 1R1W bin memory, with forwarding of the previous write; a
// clear resets all per-bin valid flags together, so no clearing pass is needed after reset
// or clear. A dump request waits for the pipeline to drain, then streams bin_count results
// at one per cycle while the result side keeps up; no request is taken until the last read
// has been issued and handed over. A write to bin_count holds off requests while a shared
// one-bit-per-cycle divider works out the bin width (100 / bin_count) and then its reciprocal
// for the sample binning.

module fixed_width_histogram #(
  parameter int unsigned MAX_BINS    = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fwh_smp_if.sink                      smp_i,
  fwh_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fwh_pkg::APB_AW-1:0]   paddr,
  input  logic [fwh_pkg::APB_DW-1:0]   pwdata,
  output logic [fwh_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned IDX_W       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned RESET_BINS  = (MAX_BINS < fwh_pkg::RESET_BIN_COUNT) ?
                                        MAX_BINS : fwh_pkg::RESET_BIN_COUNT;
  localparam int unsigned RESET_WIDTH = fwh_pkg::VALUE_SPAN / RESET_BINS;
  localparam int unsigned RESET_RECIP = (1 << fwh_pkg::RECIP_SHIFT) / RESET_WIDTH + 1;

  localparam int unsigned BW = fwh_pkg::BINS_W;
  localparam int unsigned DW = fwh_pkg::DIV_W;
  localparam int unsigned PW = fwh_pkg::PROD_W;

  fwh_pkg::state_e   state_q, state_d;
  fwh_pkg::div_req_t div_req;
  fwh_pkg::div_rsp_t div_rsp;

  logic [BW-1:0] bins_q, bins_d;
  logic [BW-1:0] width_q, width_d;
  logic [DW-1:0] recip_q, recip_d;
  logic [BW-1:0] cfg_raw, cfg_bins, div_width;
  logic          cfg_wr, acc;

  // pipeline
  logic          s1_vld_q, s1_vld_d, s1_clr_q, s1_clr_d;
  logic [PW-1:0] s1_prod_q, s1_prod_d;
  logic [BW-1:0] s1_raw, s1_idx;
  logic          s2_vld_q, s2_clr_q;
  logic [IDX_W-1:0] s2_idx_q;
  logic          fwd_add_q, fwd_clr_q;
  logic [IDX_W-1:0] fwd_idx_q;
  logic [COUNT_WIDTH-1:0] fwd_val_q;
  logic [COUNT_WIDTH-1:0] base, incr;

  // memory
  logic [COUNT_WIDTH-1:0] mem_q [MAX_BINS];
  logic [MAX_BINS-1:0]    valid_q;
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic                   rd_hit_q;
  logic                   rd_en, wr_en;
  logic [IDX_W-1:0]       rd_addr;

  // dump
  logic [BW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d, pend_last_q;
  logic [BW-1:0] pend_idx_q;
  logic          issue, move;
  logic          out_vld_q, out_last_q;
  logic [BW-1:0] out_idx_q;
  logic [COUNT_WIDTH-1:0] out_total_q;

  fwh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pready = 1'b1;
  assign prdata = (paddr == fwh_pkg::ADDR_BIN_COUNT) ? fwh_pkg::APB_DW'(bins_q) : '0;
  assign cfg_wr = psel && penable && pwrite && (paddr == fwh_pkg::ADDR_BIN_COUNT);
  assign cfg_raw  = pwdata[BW-1:0];
  assign cfg_bins = (cfg_raw == '0) ? BW'(1) :
                    (32'(cfg_raw) > MAX_BINS) ? BW'(MAX_BINS) : cfg_raw;
  assign div_width = (div_rsp.quotient == '0) ? BW'(1) : div_rsp.quotient[BW-1:0];

  assign smp_i.ready = (state_q == fwh_pkg::ST_RUN);
  assign acc         = smp_i.valid && smp_i.ready;

  // clamp to the last bin in use
  assign s1_raw = s1_prod_q[fwh_pkg::RECIP_SHIFT +: BW];
  assign s1_idx = (s1_raw >= bins_q) ? (bins_q - BW'(1)) : s1_raw;

  assign move  = pend_q && (!out_vld_q || res_o.ready);
  assign issue = (state_q == fwh_pkg::ST_DUMP) && (cnt_q < bins_q) && (!pend_q || move);

  assign rd_en   = issue || (s1_vld_q && !s1_clr_q);
  assign rd_addr = issue ? cnt_q[IDX_W-1:0] : s1_idx[IDX_W-1:0];

  always_comb begin
    if (fwd_clr_q) begin
      base = '0;
    end else if (fwd_add_q && (fwd_idx_q == s2_idx_q)) begin
      base = fwd_val_q;
    end else begin
      base = rd_hit_q ? rdata_q : '0;
    end
    incr = (&base) ? base : base + COUNT_WIDTH'(1);
  end

  assign wr_en = s2_vld_q && !s2_clr_q;

  always_comb begin
    state_d   = state_q;
    bins_d    = bins_q;
    width_d   = width_q;
    recip_d   = recip_q;
    div_req   = '0;
    s1_vld_d  = 1'b0;
    s1_clr_d  = 1'b0;
    s1_prod_d = PW'(smp_i.sample_value) * PW'(recip_q);
    cnt_d     = cnt_q;
    pend_d    = pend_q;

    if (issue) begin
      cnt_d  = cnt_q + BW'(1);
      pend_d = 1'b1;
    end else if (move) begin
      pend_d = 1'b0;
    end

    case (state_q)
      fwh_pkg::ST_RUN: begin
        if (acc) begin
          case (smp_i.mode)
            fwh_pkg::MODE_ADD: begin
              s1_vld_d = 1'b1;
            end
            fwh_pkg::MODE_CLEAR: begin
              s1_vld_d = 1'b1;
              s1_clr_d = 1'b1;
            end
            fwh_pkg::MODE_DUMP: begin
              state_d = fwh_pkg::ST_DRAIN;
            end
            default: ;
          endcase
        end
      end
      fwh_pkg::ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = fwh_pkg::ST_DUMP;
          cnt_d   = '0;
        end
      end
      fwh_pkg::ST_DUMP: begin
        if ((cnt_q == bins_q) && (!pend_q || move)) begin
          state_d = fwh_pkg::ST_RUN;
        end
      end
      fwh_pkg::ST_DIV_WIDTH: begin
        if (div_rsp.done) begin
          width_d          = div_width;
          div_req.start    = 1'b1;
          div_req.dividend = DW'(1 << fwh_pkg::RECIP_SHIFT);
          div_req.divisor  = div_width;
          state_d          = fwh_pkg::ST_DIV_RECIP;
        end
      end
      fwh_pkg::ST_DIV_RECIP: begin
        if (div_rsp.done) begin
          recip_d = div_rsp.quotient + DW'(1);
          state_d = fwh_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = fwh_pkg::ST_RUN;
      end
    endcase

    if (cfg_wr) begin
      bins_d           = cfg_bins;
      div_req.start    = 1'b1;
      div_req.dividend = DW'(fwh_pkg::VALUE_SPAN);
      div_req.divisor  = cfg_bins;
      state_d          = fwh_pkg::ST_DIV_WIDTH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fwh_pkg::ST_RUN;
      bins_q    <= BW'(RESET_BINS);
      width_q   <= BW'(RESET_WIDTH);
      recip_q   <= DW'(RESET_RECIP);
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      fwd_add_q <= 1'b0;
      fwd_clr_q <= 1'b0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bins_q    <= bins_d;
      width_q   <= width_d;
      recip_q   <= recip_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s1_vld_q;
      fwd_add_q <= wr_en;
      fwd_clr_q <= s2_vld_q && s2_clr_q;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_clr_q  <= s1_clr_d;
    s1_prod_q <= s1_prod_d;
    s2_clr_q  <= s1_clr_q;
    s2_idx_q  <= s1_idx[IDX_W-1:0];
    fwd_idx_q <= s2_idx_q;
    fwd_val_q <= incr;
    if (issue) begin
      pend_idx_q  <= cnt_q;
      pend_last_q <= ((cnt_q + BW'(1)) == bins_q);
    end
    if (move) begin
      out_idx_q   <= pend_idx_q;
      out_last_q  <= pend_last_q;
      out_total_q <= rd_hit_q ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (s2_vld_q && s2_clr_q) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[s2_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s2_idx_q] <= incr;
    end
    if (rd_en) begin
      rdata_q  <= mem_q[rd_addr];
      rd_hit_q <= valid_q[rd_addr];
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.bin_index = out_idx_q[fwh_pkg::IDX_OUT_W-1:0];
  assign res_o.bin_total = fwh_pkg::TOTAL_W'(out_total_q);
  assign res_o.last_bin  = out_last_q;

  a_dump_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fwh_pkg::ST_DUMP) |-> (!s1_vld_q && !s2_vld_q))
    else $error("dump running with add or clear still in flight");

  a_res_from_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == fwh_pkg::ST_DUMP))
    else $error("result raised outside a dump");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == fwh_pkg::ST_DIV_WIDTH || state_q == fwh_pkg::ST_DIV_RECIP))
    else $error("divider finished with no division outstanding");

endmodule

/* hdl/fwh_div.sv */
`timescale 1ns / 1ps

module fwh_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fwh_pkg::div_req_t req_i,
  output fwh_pkg::div_rsp_t rsp_o
);

  logic [fwh_pkg::DIV_W-1:0]  quo_q, quo_d;
  logic [fwh_pkg::BINS_W-1:0] rem_q, rem_d;
  logic [fwh_pkg::BINS_W-1:0] dvs_q, dvs_d;
  logic [fwh_pkg::STEP_W-1:0] step_q, step_d;
  logic                       done_q, done_d;
  logic [fwh_pkg::BINS_W:0]   trial;
  logic [fwh_pkg::BINS_W:0]   diff;
  logic                       fits;

  assign trial = {rem_q, quo_q[fwh_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      step_d = fwh_pkg::STEP_W'(fwh_pkg::DIV_W);
    end else if (step_q != '0) begin
      rem_d  = fits ? diff[fwh_pkg::BINS_W-1:0] : trial[fwh_pkg::BINS_W-1:0];
      quo_d  = {quo_q[fwh_pkg::DIV_W-2:0], fits};
      step_d = step_q - fwh_pkg::STEP_W'(1);
      done_d = (step_q == fwh_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
